/* hdl/mkc_pkg.sv */
`timescale 1ns / 1ps

package mkc_pkg;

    // table depth
    localparam int unsigned MKC_ENTRIES = 1024;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned MODE_W  = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

    // input request
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [KEY_W-1:0]  key;
    } t_in_req;

    // result
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               status;
    } t_out_rsp;

    // request as it travels from cell to cell
    typedef struct packed {
        logic                     valid;
        logic [MODE_W-1:0]        mode;
        logic signed [KEY_W-1:0]  key;
        logic                     found;
        logic [COUNT_W-1:0]       count;
    } t_link;

endpackage

/* hdl/multiset_key_counter.sv */
`timescale 1ns / 1ps
// path: a request passes through every registered cell in order, from request accept to result valid
// throughput: one request per cycle unless stalled; the whole cell chain advances together
// and holds while a result waits at the output under stall
// reset: synchronous active low, clears every cell's valid mark and the chain;
// stored keys and counts are not cleared and are unused until written

module multiset_key_counter
    import mkc_pkg::*;
#(
    parameter int unsigned ENTRIES = MKC_ENTRIES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_data
);

    t_link links [ENTRIES+1];
    logic  advance;
    t_link tail;

    // chain moves when the tail slot is empty or being taken
    assign tail       = links[ENTRIES];
    assign advance    = !tail.valid || !i_out_stall;
    assign o_in_stall = !advance;

    // request entering the first cell
    assign links[0] = {i_in_valid, i_in_data.mode, i_in_data.key, 1'b0, COUNT_ZERO};

    // row of cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mkc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_link  (links[g]),
            .o_link  (links[g+1])
        );
    end

    // result from the end of the chain
    assign o_out_valid      = tail.valid;
    assign o_out_data.count = tail.found ? tail.count : COUNT_ZERO;
    assign o_out_data.status = (tail.mode == MODE_INSERT && !tail.found)
                               ? STATUS_FULL : STATUS_OK;

endmodule

/* hdl/mkc_cell.sv */
`timescale 1ns / 1ps

module mkc_cell
    import mkc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_link i_link,
    output t_link o_link
);

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic [COUNT_W-1:0]      r_count;
    t_link                   r_link;

    logic                    n_valid;
    logic signed [KEY_W-1:0] n_key;
    logic [COUNT_W-1:0]      n_count;
    t_link                   n_link;

    logic hit;
    logic claim;

    // match against the stored key, or take a new key in the first free cell
    assign hit   = i_link.valid && r_valid && (r_key == i_link.key);
    assign claim = i_link.valid && !r_valid && !i_link.found
                   && (i_link.mode == MODE_INSERT);

    // entry update and request forwarding
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_count = r_count;
        n_link  = i_link;
        if (hit) begin
            unique case (i_link.mode)
                MODE_INSERT: begin
                    n_count = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_ONE;
                end
                MODE_DELETE: begin
                    n_count = (r_count == COUNT_ZERO) ? r_count : r_count - COUNT_ONE;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            n_link.found = 1'b1;
            n_link.count = n_count;
        end else if (claim) begin
            n_valid      = 1'b1;
            n_key        = i_link.key;
            n_count      = COUNT_ONE;
            n_link.found = 1'b1;
            n_link.count = COUNT_ONE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_link  <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
            r_link  <= n_link;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key   <= n_key;
            r_count <= n_count;
        end
    end

    assign o_link = r_link;

endmodule

/* hdl/mkc_checker.sv */
`timescale 1ns / 1ps

module mkc_checker
    import mkc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_in_req  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_rsp o_out_data
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a dropped insert reports count zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_FULL |-> o_out_data.count == COUNT_ZERO)
        else $error("full status with nonzero count");

    // input stalls exactly when a waiting result blocks the chain
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output backpressure");

    // no result right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind multiset_key_counter mkc_checker u_mkc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
